// ===== rtl/core/drpt_pkg.sv =====
// Shared types, constants and table-building functions for the dead-reckoning
// pose tracker. No dependencies; every other file in rtl/core imports this package.
package drpt_pkg;

    // Field widths
    localparam int OP_W   = 3;
    localparam int DIST_W = 24;
    localparam int TURN_W = 16;
    localparam int POS_W  = 32;
    localparam int HEAD_W = 16;

    // Angle scaling: 1/64 degree per unit
    localparam int ANGLE_FRAC_BITS = 6;
    localparam int FULL_TURN       = 360 << ANGLE_FRAC_BITS;
    localparam int HALF_TURN       = 180 << ANGLE_FRAC_BITS;
    localparam int QUARTER         = 90 << ANGLE_FRAC_BITS;
    localparam int OCTANT          = QUARTER / 2;

    // Widths of the folded angle, the angle within a quadrant and the table address
    localparam int FOLD_W = $clog2(FULL_TURN);
    localparam int ANG_W  = $clog2(QUARTER);
    localparam int ADDR_W = $clog2(OCTANT + 1);

    // pi in Q30
    localparam longint unsigned PI_Q30 = 64'd3373259426;

    // Rounding offset for the conversion to radians
    localparam longint unsigned RAD_RND = longint'(HALF_TURN / 2);

    // Taylor series divisors, (2k)(2k+1) for sine and (2k-1)(2k) for cosine
    localparam longint unsigned SIN_DIV [6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};
    localparam longint unsigned COS_DIV [6] = '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132};

    // Command codes
    typedef enum logic [OP_W-1:0] {
        OP_RESET    = 3'd0,
        OP_FORWARD  = 3'd1,
        OP_BACKWARD = 3'd2,
        OP_TURN_CCW = 3'd3,
        OP_TURN_CW  = 3'd4
    } op_t;

    // One command as held in the input register
    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [DIST_W-1:0] distance;
        logic signed [TURN_W-1:0] turn;
    } cmd_t;

    // Unsigned long division for table building; only ever evaluated at elaboration
    function automatic longint unsigned drpt_udiv(longint unsigned num, longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        int              i;
        q = '0;
        r = '0;
        for (i = 63; i >= 0; i--)
        begin
            r = {r[62:0], num[i]};
            if (r >= den)
            begin
                r    = r - den;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // Angle in table units to radians, Q30, rounded
    function automatic longint unsigned drpt_to_rad(int a);
        longint unsigned num;
        num = longint'(a) * PI_Q30 + RAD_RND;
        return drpt_udiv(num, longint'(HALF_TURN));
    endfunction

    // Q30 value to the trig fraction width, rounded half up, clamped at zero
    function automatic longint unsigned drpt_to_trig(longint q30, int tfb);
        longint unsigned v;
        int              sh;
        sh = 30 - tfb;
        v  = (q30 < 0) ? 64'd0 : longint'(q30);
        return (v + (64'd1 << (sh - 1))) >> sh;
    endfunction

    // Sine of a table angle from its Taylor series, terms truncated in Q30
    function automatic longint unsigned drpt_ser_sin(int a, int tfb);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        int              k;
        x    = drpt_to_rad(a);
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (k = 1; k <= 6; k++)
        begin
            term = drpt_udiv((term * x2) >> 30, SIN_DIV[k-1]);
            if (k[0])
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        return drpt_to_trig(sum, tfb);
    endfunction

    // Cosine of a table angle from its Taylor series, terms truncated in Q30
    function automatic longint unsigned drpt_ser_cos(int a, int tfb);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        int              k;
        x    = drpt_to_rad(a);
        x2   = (x * x) >> 30;
        term = 64'd1 << 30;
        sum  = longint'(term);
        for (k = 1; k <= 6; k++)
        begin
            term = drpt_udiv((term * x2) >> 30, COS_DIV[k-1]);
            if (k[0])
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        return drpt_to_trig(sum, tfb);
    endfunction

endpackage

// ===== rtl/core/dead_reckoning_pose_tracker_top.sv =====
// Dead-reckoning pose tracker.
// Command channel (in_valid/in_ready): opcode, distance, turn. Opcodes clear
// the pose, move forward or backward along the heading, or turn counter-
// clockwise or clockwise; unused opcodes leave the pose as it is.
// Result channel (out_valid/out_ready): pos_x, pos_y, heading and saturated,
// the pose after each command, one result per command, in order.
// An accepted command is captured in the input register, executed once the
// result stage is free, and its result is presented from the pose registers.
// Throughput: one command per cycle while out_ready is high. The heading table
// read is registered on the next heading, so a move straight after a turn sees
// the new heading. The per-cycle path is the distance-by-trig multiply,
// rounding and the saturating add.
// Reset clears the pose to zero and empties both the input and result stages.
// When the receiver stalls, the held result stays on the ports, one further
// command waits in the input register, and in_ready drops until the result
// is taken.
// Depends on drpt_pkg, drpt_heading, drpt_trig_rom and drpt_axis_step.
module dead_reckoning_pose_tracker_top #(
    parameter int TRIG_FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [drpt_pkg::OP_W-1:0]           opcode,
    input  logic signed [drpt_pkg::DIST_W-1:0]  distance,
    input  logic signed [drpt_pkg::TURN_W-1:0]  turn,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [drpt_pkg::POS_W-1:0]   pos_x,
    output logic signed [drpt_pkg::POS_W-1:0]   pos_y,
    output logic signed [drpt_pkg::HEAD_W-1:0]  heading,
    output logic                                saturated
);
    import drpt_pkg::*;

    localparam int TW = TRIG_FRAC_BITS + 2;

    cmd_t                     cmd_reg;
    logic                     cmd_valid_reg;
    logic                     cmd_valid_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic signed [POS_W-1:0]  x_reg;
    logic signed [POS_W-1:0]  x_next;
    logic signed [POS_W-1:0]  y_reg;
    logic signed [POS_W-1:0]  y_next;
    logic signed [HEAD_W-1:0] orient_reg;
    logic signed [HEAD_W-1:0] orient_next;
    logic                     sat_reg;
    logic                     sat_next;

    logic                     fire;
    logic                     in_take;
    logic                     is_move;
    logic signed [HEAD_W-1:0] orient_upd;
    logic signed [TW-1:0]     sin_val;
    logic signed [TW-1:0]     cos_val;
    logic signed [POS_W-1:0]  x_upd;
    logic signed [POS_W-1:0]  y_upd;
    logic                     x_sat;
    logic                     y_sat;

    // Handshake: execute when the result stage is free or being emptied
    assign fire     = cmd_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !cmd_valid_reg || fire;
    assign in_take  = in_valid && in_ready;
    assign is_move  = (cmd_reg.op == OP_FORWARD) || (cmd_reg.op == OP_BACKWARD);

    drpt_heading u_heading (
        .cmd             (cmd_reg),
        .orientation     (orient_reg),
        .orientation_upd (orient_upd)
    );

    drpt_trig_rom #(
        .TFB (TRIG_FRAC_BITS)
    ) u_trig (
        .clk              (clk),
        .rst_n            (rst_n),
        .orientation_next (orient_next),
        .sin_val          (sin_val),
        .cos_val          (cos_val)
    );

    drpt_axis_step #(
        .TFB (TRIG_FRAC_BITS)
    ) u_step_x (
        .pos      (x_reg),
        .distance (cmd_reg.distance),
        .trig     (cos_val),
        .backward (cmd_reg.op == OP_BACKWARD),
        .pos_upd  (x_upd),
        .sat      (x_sat)
    );

    drpt_axis_step #(
        .TFB (TRIG_FRAC_BITS)
    ) u_step_y (
        .pos      (y_reg),
        .distance (cmd_reg.distance),
        .trig     (sin_val),
        .backward (cmd_reg.op == OP_BACKWARD),
        .pos_upd  (y_upd),
        .sat      (y_sat)
    );

    // Next pose and flag; hold everything unless a command executes
    always_comb
    begin
        x_next      = x_reg;
        y_next      = y_reg;
        orient_next = orient_reg;
        sat_next    = sat_reg;
        if (fire)
        begin
            orient_next = orient_upd;
            sat_next    = 1'b0;
            case (cmd_reg.op)
                OP_RESET:
                begin
                    x_next = '0;
                    y_next = '0;
                end
                OP_FORWARD, OP_BACKWARD:
                begin
                    x_next   = x_upd;
                    y_next   = y_upd;
                    sat_next = is_move && (x_sat || y_sat);
                end
                default:
                begin
                    x_next = x_reg;
                    y_next = y_reg;
                end
            endcase
        end
    end

    // Stage occupancy
    always_comb
    begin
        if (in_take)
            cmd_valid_next = 1'b1;
        else if (fire)
            cmd_valid_next = 1'b0;
        else
            cmd_valid_next = cmd_valid_reg;

        if (fire)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Control and pose state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            x_reg         <= '0;
            y_reg         <= '0;
            orient_reg    <= '0;
            sat_reg       <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
            out_valid_reg <= out_valid_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            orient_reg    <= orient_next;
            sat_reg       <= sat_next;
        end
    end

    // Capture the incoming transaction
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_reg.op       <= opcode;
            cmd_reg.distance <= distance;
            cmd_reg.turn     <= turn;
        end
    end

    // The pose registers double as the result register
    assign out_valid = out_valid_reg;
    assign pos_x     = x_reg;
    assign pos_y     = y_reg;
    assign heading   = orient_reg;
    assign saturated = sat_reg;

endmodule

// ===== rtl/core/drpt_heading.sv =====
// Heading update: applies a turn command and wraps the result by full turns; a reset command clears it.
// Depends on drpt_pkg.
module drpt_heading (
    input  drpt_pkg::cmd_t                   cmd,
    input  logic signed [drpt_pkg::HEAD_W-1:0] orientation,
    output logic signed [drpt_pkg::HEAD_W-1:0] orientation_upd
);
    import drpt_pkg::*;

    // Sum width covers the heading plus or minus any turn field value
    localparam int SUM_W = ((HEAD_W > TURN_W) ? HEAD_W : TURN_W) + 2;
    localparam logic signed [SUM_W-1:0] FT  = SUM_W'(FULL_TURN);
    localparam logic signed [SUM_W-1:0] FT2 = SUM_W'(2 * FULL_TURN);

    logic signed [SUM_W-1:0] o_ext;
    logic signed [SUM_W-1:0] t_ext;
    logic signed [SUM_W-1:0] raw;
    logic signed [SUM_W-1:0] wrapped;

    assign o_ext = SUM_W'(orientation);
    assign t_ext = SUM_W'(cmd.turn);
    assign raw   = (cmd.op == OP_TURN_CW) ? (o_ext - t_ext) : (o_ext + t_ext);

    // Pull back by one or two full turns; exactly +-360 degrees is kept
    always_comb
    begin
        if (raw > FT2)
            wrapped = raw - FT2;
        else if (raw > FT)
            wrapped = raw - FT;
        else if (raw < -FT2)
            wrapped = raw + FT2;
        else if (raw < -FT)
            wrapped = raw + FT;
        else
            wrapped = raw;
    end

    // Select the new heading by command
    always_comb
    begin
        case (cmd.op)
            OP_RESET:    orientation_upd = '0;
            OP_TURN_CCW: orientation_upd = wrapped[HEAD_W-1:0];
            OP_TURN_CW:  orientation_upd = wrapped[HEAD_W-1:0];
            default:     orientation_upd = orientation;
        endcase
    end

endmodule

// ===== rtl/core/drpt_trig_rom.sv =====
// Sine/cosine of the heading: octant fold, registered table read, quadrant unfold.
// Depends on drpt_pkg (table functions and angle constants).
module drpt_trig_rom #(
    parameter int TFB = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic signed [drpt_pkg::HEAD_W-1:0] orientation_next,
    output logic signed [TFB+1:0]              sin_val,
    output logic signed [TFB+1:0]              cos_val
);
    import drpt_pkg::*;

    localparam int RW = TFB + 1;
    localparam int TW = TFB + 2;
    localparam int FW = HEAD_W + 1;
    localparam logic [RW-1:0] SIN0 = RW'(drpt_ser_sin(0, TFB));
    localparam logic [RW-1:0] COS0 = RW'(drpt_ser_cos(0, TFB));

    logic [RW-1:0] sin_tab [OCTANT+1];
    logic [RW-1:0] cos_tab [OCTANT+1];

    logic signed [FW-1:0] o_ext;
    logic signed [FW-1:0] hh_ext;
    logic [FOLD_W-1:0]    hh;
    logic [1:0]           quad;
    logic [FOLD_W-1:0]    a_full;
    logic [ANG_W-1:0]     a;
    logic                 swap;
    logic [ADDR_W-1:0]    addr;

    logic [RW-1:0] sin_mag_reg;
    logic [RW-1:0] cos_mag_reg;
    logic [1:0]    quad_reg;
    logic          swap_reg;

    logic [RW-1:0]        s_base;
    logic [RW-1:0]        c_base;
    logic signed [TW-1:0] s_pos;
    logic signed [TW-1:0] c_pos;

    // Build the first-octant table at elaboration
    for (genvar i = 0; i <= OCTANT; i++)
    begin : g_tab
        localparam logic [RW-1:0] SIN_V = RW'(drpt_ser_sin(i, TFB));
        localparam logic [RW-1:0] COS_V = RW'(drpt_ser_cos(i, TFB));
        assign sin_tab[i] = SIN_V;
        assign cos_tab[i] = COS_V;
    end

    // Fold the heading into one full turn, then into a quadrant
    assign o_ext = FW'(orientation_next);
    always_comb
    begin
        if (o_ext < 0)
            hh_ext = o_ext + FW'(FULL_TURN);
        else if (o_ext == FW'(FULL_TURN))
            hh_ext = '0;
        else
            hh_ext = o_ext;
    end
    assign hh = hh_ext[FOLD_W-1:0];

    always_comb
    begin
        if (hh >= FOLD_W'(3 * QUARTER))
        begin
            quad   = 2'd3;
            a_full = hh - FOLD_W'(3 * QUARTER);
        end
        else if (hh >= FOLD_W'(2 * QUARTER))
        begin
            quad   = 2'd2;
            a_full = hh - FOLD_W'(2 * QUARTER);
        end
        else if (hh >= FOLD_W'(QUARTER))
        begin
            quad   = 2'd1;
            a_full = hh - FOLD_W'(QUARTER);
        end
        else
        begin
            quad   = 2'd0;
            a_full = hh;
        end
    end
    assign a = a_full[ANG_W-1:0];

    // Mirror the upper half of the quadrant onto the first octant
    assign swap = (a > ANG_W'(OCTANT));
    always_comb
    begin
        if (swap)
            addr = ADDR_W'(ANG_W'(QUARTER) - a);
        else
            addr = a[ADDR_W-1:0];
    end

    // Registered table read, aligned with the heading register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sin_mag_reg <= SIN0;
            cos_mag_reg <= COS0;
            quad_reg    <= 2'd0;
            swap_reg    <= 1'b0;
        end
        else
        begin
            sin_mag_reg <= sin_tab[addr];
            cos_mag_reg <= cos_tab[addr];
            quad_reg    <= quad;
            swap_reg    <= swap;
        end
    end

    // Unfold: undo the mirror, then apply the quadrant signs
    assign s_base = swap_reg ? cos_mag_reg : sin_mag_reg;
    assign c_base = swap_reg ? sin_mag_reg : cos_mag_reg;
    assign s_pos  = $signed({1'b0, s_base});
    assign c_pos  = $signed({1'b0, c_base});

    always_comb
    begin
        case (quad_reg)
            2'd0:
            begin
                sin_val = s_pos;
                cos_val = c_pos;
            end
            2'd1:
            begin
                sin_val = c_pos;
                cos_val = -s_pos;
            end
            2'd2:
            begin
                sin_val = -s_pos;
                cos_val = -c_pos;
            end
            default:
            begin
                sin_val = -c_pos;
                cos_val = s_pos;
            end
        endcase
    end

endmodule

// ===== rtl/core/drpt_axis_step.sv =====
// One axis of a move: distance times trig value, rounded, added and saturated.
// Depends on drpt_pkg (field widths).
module drpt_axis_step #(
    parameter int TFB = 16
) (
    input  logic signed [drpt_pkg::POS_W-1:0]  pos,
    input  logic signed [drpt_pkg::DIST_W-1:0] distance,
    input  logic signed [TFB+1:0]              trig,
    input  logic                               backward,
    output logic signed [drpt_pkg::POS_W-1:0]  pos_upd,
    output logic                               sat
);
    import drpt_pkg::*;

    localparam int TW = TFB + 2;
    localparam int PW = DIST_W + TW;
    localparam int MW = PW - TFB;
    localparam int SW = POS_W + 2;
    localparam logic signed [SW-1:0] POS_MAX = SW'({1'b0, {(POS_W-1){1'b1}}});
    localparam logic signed [SW-1:0] POS_MIN = -POS_MAX - SW'(1);

    logic signed [PW-1:0] d_ext;
    logic signed [PW-1:0] t_ext;
    logic signed [PW-1:0] prod;
    logic                 neg;
    logic [PW-1:0]        mag;
    logic [PW-1:0]        mag_rnd;
    logic [MW-1:0]        step;
    logic signed [SW-1:0] pos_ext;
    logic signed [SW-1:0] step_ext;
    logic signed [SW-1:0] sum;

    // Product, then round its magnitude half away from zero
    assign d_ext   = PW'(distance);
    assign t_ext   = PW'(trig);
    assign prod    = d_ext * t_ext;
    assign neg     = prod[PW-1];
    assign mag     = neg ? PW'(-prod) : PW'(prod);
    assign mag_rnd = mag + (PW'(1) << (TFB - 1));
    assign step    = mag_rnd[PW-1:TFB];

    // Backward flips the direction of the step
    assign pos_ext  = SW'(pos);
    assign step_ext = SW'({1'b0, step});
    assign sum      = (neg ^ backward) ? (pos_ext - step_ext) : (pos_ext + step_ext);

    // Clip to the position range and flag it
    always_comb
    begin
        if (sum > POS_MAX)
        begin
            pos_upd = POS_MAX[POS_W-1:0];
            sat     = 1'b1;
        end
        else if (sum < POS_MIN)
        begin
            pos_upd = POS_MIN[POS_W-1:0];
            sat     = 1'b1;
        end
        else
        begin
            pos_upd = sum[POS_W-1:0];
            sat     = 1'b0;
        end
    end

endmodule

// ===== rtl/core/drpt_checker.sv =====
// Port-level checks for the pose tracker, bound to the top level.
// Depends on drpt_pkg and dead_reckoning_pose_tracker_top.
module drpt_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [drpt_pkg::POS_W-1:0]   pos_x,
    input logic signed [drpt_pkg::POS_W-1:0]   pos_y,
    input logic signed [drpt_pkg::HEAD_W-1:0]  heading,
    input logic                                saturated
);
    import drpt_pkg::*;

    localparam logic signed [POS_W-1:0] PMAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] PMIN = {1'b1, {(POS_W-1){1'b0}}};

    // Heading stays within one full turn either way
    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (heading <= HEAD_W'(FULL_TURN)) && (heading >= -HEAD_W'(FULL_TURN)))
        else $error("heading outside one full turn");

    // A saturated result has a coordinate at a range limit
    a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && saturated) |->
            (pos_x == PMAX) || (pos_x == PMIN) || (pos_y == PMAX) || (pos_y == PMIN))
        else $error("saturated flag without a clipped coordinate");

    // Every accepted command yields a valid result on the output
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> ##1 out_valid)
        else $error("no result after an accepted command");

    // A stalled result holds
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            out_valid && $stable(pos_x) && $stable(pos_y) && $stable(heading)
            && $stable(saturated))
        else $error("result changed while stalled");

endmodule

bind dead_reckoning_pose_tracker_top drpt_checker u_drpt_checker (.*);
